// File: hdl/terrain_bilinear_nodata_interp_core_macros.svh
// Assertion shorthands; clk and rst_n must be in scope at the point of use.
`ifndef TERRAIN_BILINEAR_NODATA_INTERP_CORE_MACROS_SVH
`define TERRAIN_BILINEAR_NODATA_INTERP_CORE_MACROS_SVH

// same-cycle implication
`define TBNI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBNI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tbni_pkg.sv
package tbni_pkg;

  localparam int POST_W            = 16;
  localparam int VAL_W             = 15;
  localparam int FRAC_IN_W         = 16;
  localparam int ELEV_W            = 23;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int OUT_FRAC_BITS_DEF = 8;

  localparam logic [POST_W-1:0]        POST_NODATA = 16'hFFFF;
  localparam logic [POST_W-1:0]        POST_SIGN   = 16'h8000;
  localparam logic [POST_W-1:0]        POST_MAG    = 16'h7FFF;
  localparam logic signed [POST_W-1:0] ELEV_MIN    = -16'sd12000;
  localparam logic signed [POST_W-1:0] ELEV_MAX    = 16'sd9000;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] val;
  } post_t;

  function automatic int frac_use_w(input int frac_bits);
    return (frac_bits < FRAC_IN_W) ? frac_bits : FRAC_IN_W;
  endfunction

  function automatic post_t decode_post(input logic [POST_W-1:0] raw);
    post_t                    d;
    logic [POST_W-1:0]        mag;
    logic signed [POST_W-1:0] v;
    mag   = raw & POST_MAG;
    v     = ((raw & POST_SIGN) != '0) ? -signed'(mag) : signed'(mag);
    d.ok  = (raw != POST_NODATA) && (v >= ELEV_MIN) && (v <= ELEV_MAX);
    d.val = d.ok ? v[VAL_W-1:0] : '0;
    return d;
  endfunction

endpackage

// File: hdl/tbni_if.sv
interface tbni_in_if;
  import tbni_pkg::*;

  logic              valid;
  logic              ready;
  logic [POST_W-1:0] post_sw;
  logic [POST_W-1:0] post_nw;
  logic [POST_W-1:0] post_se;
  logic [POST_W-1:0] post_ne;
  logic [FRAC_IN_W-1:0] frac_x;
  logic [FRAC_IN_W-1:0] frac_y;

  modport source (output valid, post_sw, post_nw, post_se, post_ne, frac_x, frac_y,
                  input ready);
  modport sink (input valid, post_sw, post_nw, post_se, post_ne, frac_x, frac_y,
                output ready);
endinterface

interface tbni_out_if;
  import tbni_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEV_W-1:0] elevation;
  logic                     valid_res;

  modport source (output valid, elevation, valid_res, input ready);
  modport sink (input valid, elevation, valid_res, output ready);
endinterface

// File: hdl/tbni_decode.sv
module tbni_decode #(
  parameter int FRAC_BITS = tbni_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [tbni_pkg::POST_W-1:0]                   post_sw,
  input  logic [tbni_pkg::POST_W-1:0]                   post_nw,
  input  logic [tbni_pkg::POST_W-1:0]                   post_se,
  input  logic [tbni_pkg::POST_W-1:0]                   post_ne,
  input  logic [tbni_pkg::FRAC_IN_W-1:0]                frac_x,
  input  logic [tbni_pkg::FRAC_IN_W-1:0]                frac_y,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic signed [tbni_pkg::VAL_W-1:0]             sa,
  output logic signed [tbni_pkg::VAL_W-1:0]             sb,
  output logic signed [tbni_pkg::VAL_W-1:0]             na,
  output logic signed [tbni_pkg::VAL_W-1:0]             nb,
  output logic [tbni_pkg::frac_use_w(FRAC_BITS)-1:0]    fx,
  output logic [tbni_pkg::frac_use_w(FRAC_BITS)-1:0]    fy,
  output logic                                          vres
);
  import tbni_pkg::*;

  localparam int FXW = frac_use_w(FRAC_BITS);

  post_t                   sw, nw, se, ne;
  logic signed [VAL_W-1:0] sa_p, sb_p, na_p, nb_p;
  logic signed [VAL_W-1:0] sa_nxt, sb_nxt, na_nxt, nb_nxt;
  logic                    hs, hn, ld;
  logic                    v_r, vres_r;
  logic signed [VAL_W-1:0] sa_r, sb_r, na_r, nb_r;
  logic [FXW-1:0]          fx_r, fy_r;

  always_comb begin
    sw = decode_post(post_sw);
    nw = decode_post(post_nw);
    se = decode_post(post_se);
    ne = decode_post(post_ne);
    // replace a missing post by its row partner
    sa_p = sw.ok ? sw.val : se.val;
    sb_p = se.ok ? se.val : sw.val;
    na_p = nw.ok ? nw.val : ne.val;
    nb_p = ne.ok ? ne.val : nw.val;
    hs   = sw.ok | se.ok;
    hn   = nw.ok | ne.ok;
    // replace a missing row by the other row
    sa_nxt = hs ? sa_p : na_p;
    sb_nxt = hs ? sb_p : nb_p;
    na_nxt = hn ? na_p : sa_p;
    nb_nxt = hn ? nb_p : sb_p;
  end

  assign ld       = !v_r || out_ready;
  assign in_ready = ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ld) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      sa_r   <= sa_nxt;
      sb_r   <= sb_nxt;
      na_r   <= na_nxt;
      nb_r   <= nb_nxt;
      fx_r   <= frac_x[FXW-1:0];
      fy_r   <= frac_y[FXW-1:0];
      vres_r <= hs | hn;
    end
  end

  assign out_valid = v_r;
  assign sa        = sa_r;
  assign sb        = sb_r;
  assign na        = na_r;
  assign nb        = nb_r;
  assign fx        = fx_r;
  assign fy        = fy_r;
  assign vres      = vres_r;

endmodule

// File: hdl/tbni_row_lerp.sv
module tbni_row_lerp #(
  parameter int FRAC_BITS = tbni_pkg::FRAC_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  logic signed [tbni_pkg::VAL_W-1:0]                  sa,
  input  logic signed [tbni_pkg::VAL_W-1:0]                  sb,
  input  logic signed [tbni_pkg::VAL_W-1:0]                  na,
  input  logic signed [tbni_pkg::VAL_W-1:0]                  nb,
  input  logic [tbni_pkg::frac_use_w(FRAC_BITS)-1:0]         fx,
  input  logic [tbni_pkg::frac_use_w(FRAC_BITS)-1:0]         fy,
  input  logic                                               vres,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output logic signed [tbni_pkg::VAL_W+FRAC_BITS-1:0]        s_row,
  output logic signed [tbni_pkg::VAL_W+FRAC_BITS-1:0]        n_row,
  output logic [tbni_pkg::frac_use_w(FRAC_BITS)-1:0]         fy_out,
  output logic                                               vres_out
);
  import tbni_pkg::*;

  localparam int FXW = frac_use_w(FRAC_BITS);
  localparam int DFW = VAL_W + 1;
  localparam int PW  = VAL_W + 1 + FXW;
  localparam int RW  = VAL_W + FRAC_BITS;
  localparam int XW  = ((PW > RW) ? PW : RW) + 1;
  localparam int NS  = 2;

  logic [NS-1:0]           v_r, ld, v_in;
  logic signed [DFW-1:0]   ds, dn;
  logic signed [PW-1:0]    ps_nxt, pn_nxt, ps_r, pn_r;
  logic signed [PW-1:0]    fx_ext;
  logic signed [VAL_W-1:0] sa_r, na_r;
  logic [FXW-1:0]          fy_a_r, fy_b_r;
  logic                    vres_a_r, vres_b_r;
  logic signed [XW-1:0]    s_sum, n_sum;
  logic signed [RW-1:0]    s_r, n_r;

  always_comb begin
    ld[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign v_in     = {v_r[NS-2:0], in_valid};
  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_in & ld) | (v_r & ~ld);
    end
  end

  // stage A: x differences times fraction
  always_comb begin
    ds     = DFW'(sb) - DFW'(sa);
    dn     = DFW'(nb) - DFW'(na);
    fx_ext = PW'(signed'({1'b0, fx}));
    ps_nxt = PW'(ds) * fx_ext;
    pn_nxt = PW'(dn) * fx_ext;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ps_r     <= ps_nxt;
      pn_r     <= pn_nxt;
      sa_r     <= sa;
      na_r     <= na;
      fy_a_r   <= fy;
      vres_a_r <= vres;
    end
  end

  // stage B: add scaled west post
  always_comb begin
    s_sum = (XW'(sa_r) <<< FRAC_BITS) + XW'(ps_r);
    n_sum = (XW'(na_r) <<< FRAC_BITS) + XW'(pn_r);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s_r      <= signed'(s_sum[RW-1:0]);
      n_r      <= signed'(n_sum[RW-1:0]);
      fy_b_r   <= fy_a_r;
      vres_b_r <= vres_a_r;
    end
  end

  assign out_valid = v_r[NS-1];
  assign s_row     = s_r;
  assign n_row     = n_r;
  assign fy_out    = fy_b_r;
  assign vres_out  = vres_b_r;

endmodule

// File: hdl/tbni_col_lerp.sv
`include "terrain_bilinear_nodata_interp_core_macros.svh"

module tbni_col_lerp #(
  parameter int FRAC_BITS     = tbni_pkg::FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = tbni_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic signed [tbni_pkg::VAL_W+FRAC_BITS-1:0]   s_row,
  input  logic signed [tbni_pkg::VAL_W+FRAC_BITS-1:0]   n_row,
  input  logic [tbni_pkg::frac_use_w(FRAC_BITS)-1:0]    fy,
  input  logic                                          vres,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic signed [tbni_pkg::ELEV_W-1:0]            elevation,
  output logic                                          valid_res
);
  import tbni_pkg::*;

  localparam int FYW  = frac_use_w(FRAC_BITS);
  localparam int RW   = VAL_W + FRAC_BITS;
  localparam int DW   = RW + 1;
  localparam int LO_W = 16;
  localparam int HW   = DW - LO_W;
  localparam int HPW  = HW + FYW + 1;
  localparam int LPW  = LO_W + FYW;
  localparam int TW   = DW + FYW;
  localparam int TXW  = TW + 2;
  localparam int VW   = VAL_W + 2 * FRAC_BITS + 2;
  localparam int SH   = 2 * FRAC_BITS - OUT_FRAC_BITS;
  localparam int NS   = 4;

  logic [NS-1:0]            v_r, ld, v_in;
  logic signed [DW-1:0]     d_nxt, d_r;
  logic signed [RW-1:0]     s0_r, s1_r, s2_r;
  logic [FYW-1:0]           fy0_r;
  logic                     vres0_r, vres1_r, vres2_r, vres3_r;
  logic signed [HPW-1:0]    hp_nxt, hp_r;
  logic [LPW-1:0]           lp_nxt, lp_r;
  logic signed [TXW-1:0]    t_sum;
  logic signed [TW-1:0]     t_r;
  logic signed [VW-1:0]     sum_nxt;
  logic signed [ELEV_W-1:0] elev_nxt, elev_r;

  always_comb begin
    ld[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign v_in     = {v_r[NS-2:0], in_valid};
  assign in_ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_in & ld) | (v_r & ~ld);
    end
  end

  // stage 0: row difference
  assign d_nxt = DW'(n_row) - DW'(s_row);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      d_r     <= d_nxt;
      s0_r    <= s_row;
      fy0_r   <= fy;
      vres0_r <= vres;
    end
  end

  // stage 1: split difference times y fraction
  always_comb begin
    hp_nxt = HPW'(signed'(d_r[DW-1:LO_W])) * HPW'(signed'({1'b0, fy0_r}));
    lp_nxt = LPW'(d_r[LO_W-1:0]) * LPW'(fy0_r);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      hp_r    <= hp_nxt;
      lp_r    <= lp_nxt;
      s1_r    <= s0_r;
      vres1_r <= vres0_r;
    end
  end

  // stage 2: merge partial products
  assign t_sum = (TXW'(hp_r) <<< LO_W) + TXW'(signed'({1'b0, lp_r}));

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      t_r     <= signed'(t_sum[TW-1:0]);
      s2_r    <= s1_r;
      vres2_r <= vres1_r;
    end
  end

  // stage 3: add scaled south row, floor to output fraction
  always_comb begin
    sum_nxt  = (VW'(s2_r) <<< FRAC_BITS) + VW'(t_r);
    elev_nxt = ELEV_W'(sum_nxt >>> SH);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      elev_r  <= elev_nxt;
      vres3_r <= vres2_r;
    end
  end

  assign out_valid = v_r[NS-1];
  assign elevation = elev_r;
  assign valid_res = vres3_r;

  `TBNI_ASSERT_IMP(a_zero_when_no_data, out_valid && !valid_res, elevation == '0, "no-data item with nonzero elevation")
  `TBNI_ASSERT_IMP(a_full_stall_blocks, (&v_r) && !out_ready, !in_ready, "item taken while pipeline full and stalled")
  `TBNI_ASSERT_NXT(a_first_stage_holds, v_r[0] && !ld[0], v_r[0], "held item lost from first stage")

endmodule

// File: hdl/terrain_bilinear_nodata_interp_core.sv
// Channel  Dir  Payload                                        Handshake
// in_ch    in   post_sw, post_nw, post_se, post_ne, frac_x/y   valid/ready
// out_ch   out  elevation (23b signed, 8 frac), valid_res      valid/ready
//
// One item per cycle unless out_ch stalls; stages: decode, two x-lerp stages, four y-lerp stages.
// Stage depth is set by one 16x17 multiply (x), a split 32x17 multiply (y) and the
// final wide add.
// rst_n clears the stage valid bits only; payload registers are not reset.
// A stage holds only while the next one is full, so bubbles close up under stall.
module terrain_bilinear_nodata_interp_core #(
  parameter int FRAC_BITS     = tbni_pkg::FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = tbni_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tbni_in_if.sink   in_ch,
  tbni_out_if.source out_ch
);
  import tbni_pkg::*;

  localparam int FXW = frac_use_w(FRAC_BITS);
  localparam int RW  = VAL_W + FRAC_BITS;

  logic                    dec_valid, dec_ready;
  logic signed [VAL_W-1:0] dec_sa, dec_sb, dec_na, dec_nb;
  logic [FXW-1:0]          dec_fx, dec_fy;
  logic                    dec_vres;
  logic                    row_valid, row_ready;
  logic signed [RW-1:0]    row_s, row_n;
  logic [FXW-1:0]          row_fy;
  logic                    row_vres;

  tbni_decode #(
    .FRAC_BITS (FRAC_BITS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .post_sw   (in_ch.post_sw),
    .post_nw   (in_ch.post_nw),
    .post_se   (in_ch.post_se),
    .post_ne   (in_ch.post_ne),
    .frac_x    (in_ch.frac_x),
    .frac_y    (in_ch.frac_y),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .sa        (dec_sa),
    .sb        (dec_sb),
    .na        (dec_na),
    .nb        (dec_nb),
    .fx        (dec_fx),
    .fy        (dec_fy),
    .vres      (dec_vres)
  );

  tbni_row_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_row_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .sa        (dec_sa),
    .sb        (dec_sb),
    .na        (dec_na),
    .nb        (dec_nb),
    .fx        (dec_fx),
    .fy        (dec_fy),
    .vres      (dec_vres),
    .out_valid (row_valid),
    .out_ready (row_ready),
    .s_row     (row_s),
    .n_row     (row_n),
    .fy_out    (row_fy),
    .vres_out  (row_vres)
  );

  tbni_col_lerp #(
    .FRAC_BITS     (FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_col_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (row_valid),
    .in_ready  (row_ready),
    .s_row     (row_s),
    .n_row     (row_n),
    .fy        (row_fy),
    .vres      (row_vres),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .elevation (out_ch.elevation),
    .valid_res (out_ch.valid_res)
  );

endmodule
